// File: rtl/core/mqspq_pkg.sv
// shared constants and types for the multi-queue stable priority queue
// no dependencies; taken in by the interfaces and every module of the block
package mqspq_pkg;

    // fixed field widths of the item channels
    localparam int QIDX_W    = 3;
    localparam int PRIO_IN_W = 4;
    localparam int JOB_W     = 16;
    localparam int STATUS_W  = 2;

    // defaults for the top-level parameters
    localparam int DEF_QUEUES        = 5;
    localparam int DEF_DEPTH         = 16;
    localparam int DEF_PRIORITY_BITS = 4;

    typedef enum logic [STATUS_W-1:0] {
        ST_TAKEN    = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_INSERTED = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    // which entry of the current queue is read
    typedef enum logic [1:0] {
        RD_HEAD,
        RD_TAIL,
        RD_PREV,
        RD_NEXT
    } rd_sel_t;

    // what is written where
    typedef enum logic [1:0] {
        WR_NEW_HEAD,
        WR_NEW_UP,
        WR_MOVE_UP,
        WR_MOVE_DOWN
    } wr_sel_t;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    grab;
        logic    finish;
        status_t result;
    } cmd_t;

    typedef struct packed {
        logic q_ok;
        logic take;
        logic empty;
        logic full;
        logic ge;
        logic cur_zero;
        logic cur_last;
        logic out_free;
    } sts_t;

endpackage

// File: rtl/core/mqspq_if.sv
// item channel interfaces: request channel and response channel
// depends on mqspq_pkg for the field widths
interface mqspq_req_if;
    import mqspq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 mode;
    logic [QIDX_W-1:0]    queue_index;
    logic [PRIO_IN_W-1:0] priority_req;

    modport source (output valid, mode, queue_index, priority_req, input ready);
    modport sink (input valid, mode, queue_index, priority_req, output ready);
endinterface

interface mqspq_rsp_if;
    import mqspq_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [JOB_W-1:0]    job_number;

    modport source (output valid, status, job_number, input ready);
    modport sink (input valid, status, job_number, output ready);
endinterface

// File: rtl/core/mqspq_ctrl.sv
// sequencer for insert and take: walks one queue's entries one per cycle
// depends on mqspq_pkg for the command and status structs
module mqspq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mqspq_pkg::sts_t   sts,
    output mqspq_pkg::cmd_t   cmd
);
    import mqspq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_INS_WALK,
        S_INS_HEAD,
        S_TAKE_HEAD,
        S_TAKE_SHIFT,
        S_DONE
    } state_t;

    state_t  state_reg, state_next;
    status_t res_reg, res_next;

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        cmd        = '0;
        cmd.result = res_reg;
        in_ready   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (!sts.q_ok)
                begin
                    res_next   = sts.take ? ST_EMPTY : ST_FULL;
                    state_next = S_DONE;
                end
                else if (sts.take)
                begin
                    if (sts.empty)
                    begin
                        res_next   = ST_EMPTY;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_HEAD;
                        state_next = S_TAKE_HEAD;
                    end
                end
                else if (sts.full)
                begin
                    res_next   = ST_FULL;
                    state_next = S_DONE;
                end
                else if (sts.empty)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_NEW_HEAD;
                    res_next   = ST_INSERTED;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_TAIL;
                    state_next = S_INS_WALK;
                end
            end
            S_INS_WALK:
            begin
                cmd.wr_en = 1'b1;
                if (sts.ge)
                begin
                    // slot found just behind the entry read
                    cmd.wr_sel = WR_NEW_UP;
                    res_next   = ST_INSERTED;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.wr_sel = WR_MOVE_UP;
                    if (sts.cur_zero)
                    begin
                        state_next = S_INS_HEAD;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_PREV;
                    end
                end
            end
            S_INS_HEAD:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_NEW_HEAD;
                res_next   = ST_INSERTED;
                state_next = S_DONE;
            end
            S_TAKE_HEAD:
            begin
                cmd.grab = 1'b1;
                res_next = ST_TAKEN;
                if (sts.cur_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_NEXT;
                    state_next = S_TAKE_SHIFT;
                end
            end
            S_TAKE_SHIFT:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_MOVE_DOWN;
                if (sts.cur_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_NEXT;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            res_reg   <= ST_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

endmodule

// File: rtl/core/mqspq_dp.sv
// datapath: item registers, per-queue fill and job counters, entry memory, output register
// depends on mqspq_pkg for widths, status codes and the command and status structs
module mqspq_dp #(
    parameter int QUEUES        = mqspq_pkg::DEF_QUEUES,
    parameter int DEPTH         = mqspq_pkg::DEF_DEPTH,
    parameter int PRIORITY_BITS = mqspq_pkg::DEF_PRIORITY_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mqspq_pkg::cmd_t                cmd,
    output mqspq_pkg::sts_t                sts,
    input  logic                           mode,
    input  logic [mqspq_pkg::QIDX_W-1:0]   queue_index,
    input  logic [mqspq_pkg::PRIO_IN_W-1:0] priority_req,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [mqspq_pkg::STATUS_W-1:0] status,
    output logic [mqspq_pkg::JOB_W-1:0]    job_number
);
    import mqspq_pkg::*;

    localparam int PW      = (PRIORITY_BITS < PRIO_IN_W) ? PRIORITY_BITS : PRIO_IN_W;
    localparam int QW      = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int IW      = $clog2(DEPTH);
    localparam int FW      = $clog2(DEPTH + 1);
    localparam int ENTRIES = QUEUES * DEPTH;
    localparam int AW      = $clog2(ENTRIES);

    // item registers
    logic              take_reg;
    logic [QIDX_W-1:0] q_reg;
    logic [PW-1:0]     prio_reg;

    // per-queue state
    logic [FW-1:0]    fill_reg [QUEUES];
    logic [JOB_W-1:0] ctr_reg  [QUEUES];

    // entry memory
    logic [PW-1:0]    mem_prio [ENTRIES];
    logic [JOB_W-1:0] mem_job  [ENTRIES];
    logic [PW-1:0]    rd_prio_reg;
    logic [JOB_W-1:0] rd_job_reg;
    logic [IW-1:0]    cur_reg;

    logic [JOB_W-1:0] take_job_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [JOB_W-1:0]    job_reg;

    logic [QW-1:0]    qi;
    logic [FW-1:0]    n_w;
    logic [IW-1:0]    tail_idx;
    logic [IW-1:0]    rd_idx;
    logic [IW-1:0]    wr_idx;
    logic [AW-1:0]    base;
    logic [PW-1:0]    wr_prio;
    logic [JOB_W-1:0] wr_job;
    logic [JOB_W-1:0] job_new;

    assign qi       = QW'(q_reg);
    assign n_w      = fill_reg[qi];
    assign tail_idx = IW'(n_w - FW'(1));
    assign job_new  = ctr_reg[qi] + JOB_W'(1);
    assign base     = AW'(qi * DEPTH);

    always_comb
    begin
        case (cmd.rd_sel)
            RD_HEAD: rd_idx = '0;
            RD_TAIL: rd_idx = tail_idx;
            RD_PREV: rd_idx = cur_reg - IW'(1);
            RD_NEXT: rd_idx = cur_reg + IW'(1);
            default: rd_idx = '0;
        endcase
    end

    always_comb
    begin
        case (cmd.wr_sel)
            WR_NEW_HEAD:
            begin
                wr_idx  = '0;
                wr_prio = prio_reg;
                wr_job  = job_new;
            end
            WR_NEW_UP:
            begin
                wr_idx  = cur_reg + IW'(1);
                wr_prio = prio_reg;
                wr_job  = job_new;
            end
            WR_MOVE_UP:
            begin
                wr_idx  = cur_reg + IW'(1);
                wr_prio = rd_prio_reg;
                wr_job  = rd_job_reg;
            end
            WR_MOVE_DOWN:
            begin
                wr_idx  = cur_reg - IW'(1);
                wr_prio = rd_prio_reg;
                wr_job  = rd_job_reg;
            end
            default:
            begin
                wr_idx  = '0;
                wr_prio = prio_reg;
                wr_job  = job_new;
            end
        endcase
    end

    always_comb
    begin
        sts.q_ok     = (32'(q_reg) < QUEUES);
        sts.take     = take_reg;
        sts.empty    = (n_w == '0);
        sts.full     = (n_w == FW'(DEPTH));
        sts.ge       = (rd_prio_reg >= prio_reg);
        sts.cur_zero = (cur_reg == '0);
        sts.cur_last = (cur_reg == tail_idx);
        sts.out_free = !out_valid_reg || out_ready;
    end

    // item capture and walk registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            take_reg <= mode;
            q_reg    <= queue_index;
            prio_reg <= PW'(priority_req);
        end
        if (cmd.rd_en)
        begin
            cur_reg <= rd_idx;
        end
        if (cmd.grab)
        begin
            take_job_reg <= rd_job_reg;
        end
    end

    // single write port, single registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem_prio[base + AW'(wr_idx)] <= wr_prio;
            mem_job[base + AW'(wr_idx)]  <= wr_job;
        end
        if (cmd.rd_en)
        begin
            rd_prio_reg <= mem_prio[base + AW'(rd_idx)];
            rd_job_reg  <= mem_job[base + AW'(rd_idx)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QUEUES; i++)
            begin
                fill_reg[i] <= '0;
                ctr_reg[i]  <= '0;
            end
        end
        else if (cmd.finish)
        begin
            if (cmd.result == ST_INSERTED)
            begin
                fill_reg[qi] <= n_w + FW'(1);
                ctr_reg[qi]  <= job_new;
            end
            else if (cmd.result == ST_TAKEN)
            begin
                fill_reg[qi] <= n_w - FW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status_reg <= cmd.result;
            case (cmd.result)
                ST_INSERTED: job_reg <= job_new;
                ST_TAKEN:    job_reg <= take_job_reg;
                default:     job_reg <= '0;
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign job_number = job_reg;

endmodule

// File: rtl/core/multi_queue_stable_priority_queue.sv
// One stable priority queue per printer, QUEUES queues of DEPTH entries each, kept
// sorted in a single-port entry memory. An insert (mode 0) gets its queue's next
// 16-bit job number and goes behind every entry of equal or higher priority; a take
// (mode 1) returns the head's job number. Status: 0 taken, 1 empty (also a take from
// an out-of-range queue), 2 inserted, 3 full (also an insert into an out-of-range
// queue); an out-of-range queue index changes nothing. One item is in work at a
// time: an insert walks its queue from the tail and a take shifts the entries behind
// the head down, as the sequencer moves one entry per cycle through the memory's
// single read and write port; a rejected insert or a take from an empty queue walks
// nothing, and the longest items are an insert into a queue one short of full and a
// take from a full queue. The result sits in an output register, so the block
// returns to accepting while it waits; the next item stalls at its end only if that
// register has still not been read. The memory needs no clearing after reset.
module multi_queue_stable_priority_queue #(
    parameter int QUEUES        = mqspq_pkg::DEF_QUEUES,
    parameter int DEPTH         = mqspq_pkg::DEF_DEPTH,
    parameter int PRIORITY_BITS = mqspq_pkg::DEF_PRIORITY_BITS
) (
    input logic         clk,
    input logic         rst_n,
    mqspq_req_if.sink   req,
    mqspq_rsp_if.source rsp
);
    import mqspq_pkg::*;

    cmd_t cmd;
    sts_t sts;

    mqspq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mqspq_dp #(
        .QUEUES        (QUEUES),
        .DEPTH         (DEPTH),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .mode         (req.mode),
        .queue_index  (req.queue_index),
        .priority_req (req.priority_req),
        .out_valid    (rsp.valid),
        .out_ready    (rsp.ready),
        .status       (rsp.status),
        .job_number   (rsp.job_number)
    );

endmodule
